[hw/rtl/owtr_pkg.sv]
package owtr_pkg;

  localparam int unsigned CfgDataWidth = 20;
  localparam int unsigned CfgIdxWidth  = 2;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_RESET_LOW  = 2'd0,
    CFG_SETTLE     = 2'd1,
    CFG_CONV_WAIT  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_CONVERT = 2'd1,
    REQ_READ    = 2'd2
  } req_type_e;

  localparam logic [7:0] CMD_SKIP_ROM = 8'hcc;
  localparam logic [7:0] CMD_CONVERT  = 8'h44;
  localparam logic [7:0] CMD_READ_PAD = 8'hbe;

  localparam logic [9:0]  RESET_LOW_DEFAULT = 10'd500;
  localparam logic [9:0]  SETTLE_DEFAULT    = 10'd200;
  localparam logic [19:0] CONV_WAIT_DEFAULT = 20'd500000;

  typedef struct packed {
    logic [19:0] convert_wait_time;
    logic [9:0]  presence_settle_time;
    logic [9:0]  reset_low_time;
  } cfg_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       line_in;
  } req_t;

  typedef struct packed {
    logic        line_output_enable;
    logic        line_level;
    logic        busy_res;
    logic        done_res;
    logic        temp_valid;
    logic [15:0] temperature;
    logic        rejected;
  } res_t;

endpackage

[hw/rtl/owtr_chan_if.sv]
interface owtr_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/owtr_ctrl.sv]
module owtr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  owtr_pkg::req_t req_i,
  input  owtr_pkg::cfg_t cfg_i,
  output owtr_pkg::res_t res_o
);
  import owtr_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_RHIGH  = 4'd1,
    PH_RLOW   = 4'd2,
    PH_RGAP   = 4'd3,
    PH_RWAIT  = 4'd4,
    PH_SETTLE = 4'd5,
    PH_WRITE  = 4'd6,
    PH_READ   = 4'd7,
    PH_CONV   = 4'd8
  } phase_e;

  localparam logic [19:0] RHIGH_TICKS  = 20'd10;
  localparam logic [19:0] RGAP_TICKS   = 20'd50;
  localparam logic [10:0] SETTLE_EXTRA = 11'd10;
  localparam logic [19:0] WSLOT_TICKS  = 20'd60;
  localparam logic [19:0] RSLOT_TICKS  = 20'd50;
  localparam logic [19:0] WLOW_END     = 20'd8;
  localparam logic [19:0] WBIT_END     = 20'd58;
  localparam logic [19:0] RLOW_END     = 20'd5;
  localparam logic [19:0] RSAMPLE_AT   = 20'd10;

  phase_e      phase_q, phase_d;
  logic        op_q, op_d;
  logic [19:0] tick_q, tick_d;
  logic [2:0]  bit_q, bit_d;
  logic [1:0]  byte_q, byte_d;
  logic [7:0]  shift_q, shift_d;
  logic [15:0] temp_q, temp_d;

  logic        is_cmd;
  logic [19:0] limit;
  logic [10:0] settle_lim;
  logic [19:0] cnt_inc;
  logic        hit;
  logic [19:0] cnt_after;
  logic [2:0]  bit_inc;
  logic [1:0]  byte_inc;
  logic [7:0]  sampled;
  logic        oe, lv, done, rej;

  assign is_cmd     = (req_i.req_type == REQ_CONVERT) || (req_i.req_type == REQ_READ);
  assign settle_lim = {1'b0, cfg_i.presence_settle_time} + SETTLE_EXTRA;
  assign cnt_inc    = tick_q + 20'd1;
  assign hit        = (cnt_inc >= limit);
  assign cnt_after  = hit ? 20'd0 : cnt_inc;
  assign bit_inc    = bit_q + 3'd1;
  assign byte_inc   = byte_q + 2'd1;
  assign sampled    = (tick_q == RSAMPLE_AT) ? {req_i.line_in, shift_q[7:1]} : shift_q;

  always_comb begin
    unique case (phase_q)
      PH_RHIGH:  limit = RHIGH_TICKS;
      PH_RLOW:   limit = {10'd0, cfg_i.reset_low_time};
      PH_RGAP:   limit = RGAP_TICKS;
      PH_SETTLE: limit = {9'd0, settle_lim};
      PH_WRITE:  limit = WSLOT_TICKS;
      PH_READ:   limit = RSLOT_TICKS;
      PH_CONV:   limit = cfg_i.convert_wait_time;
      default:   limit = 20'd0;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    op_d    = op_q;
    tick_d  = tick_q;
    bit_d   = bit_q;
    byte_d  = byte_q;
    shift_d = shift_q;
    temp_d  = temp_q;
    done    = 1'b0;
    rej     = 1'b0;
    oe      = 1'b0;
    lv      = 1'b1;

    // drive of the current tick
    unique case (phase_q)
      PH_RHIGH: begin
        oe = 1'b1;
      end
      PH_RLOW: begin
        oe = 1'b1;
        lv = 1'b0;
      end
      PH_WRITE: begin
        oe = 1'b1;
        if (tick_q < WLOW_END) begin
          lv = 1'b0;
        end else if (tick_q < WBIT_END) begin
          lv = shift_q[0];
        end
      end
      PH_READ: begin
        if (tick_q < RLOW_END) begin
          oe = 1'b1;
          lv = 1'b0;
        end
      end
      PH_CONV: begin
        oe = 1'b1;
      end
      default: begin
      end
    endcase

    if (is_cmd) begin
      if (phase_q != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        op_d    = (req_i.req_type == REQ_READ);
        phase_d = PH_RHIGH;
        tick_d  = 20'd0;
        bit_d   = 3'd0;
        byte_d  = 2'd0;
        shift_d = 8'd0;
        oe      = 1'b1;
        lv      = 1'b1;
      end
    end else begin
      unique case (phase_q)
        PH_IDLE: begin
        end
        PH_RHIGH: begin
          tick_d = cnt_after;
          if (hit) begin
            phase_d = (cfg_i.reset_low_time == 10'd0) ? PH_RGAP : PH_RLOW;
          end
        end
        PH_RLOW: begin
          tick_d = cnt_after;
          if (hit) begin
            phase_d = PH_RGAP;
          end
        end
        PH_RGAP: begin
          tick_d = cnt_after;
          if (hit) begin
            phase_d = PH_RWAIT;
          end
        end
        PH_RWAIT: begin
          if (!req_i.line_in) begin
            phase_d = PH_SETTLE;
            tick_d  = 20'd0;
          end
        end
        PH_SETTLE: begin
          tick_d = cnt_after;
          if (hit) begin
            byte_d  = 2'd0;
            phase_d = PH_WRITE;
            bit_d   = 3'd0;
            shift_d = CMD_SKIP_ROM;
          end
        end
        PH_WRITE: begin
          tick_d = cnt_after;
          if (hit) begin
            shift_d = {1'b0, shift_q[7:1]};
            bit_d   = bit_inc;
            if (bit_inc == 3'd0) begin
              byte_d = byte_inc;
              if (byte_inc == 2'd1) begin
                bit_d   = 3'd0;
                shift_d = op_q ? CMD_READ_PAD : CMD_CONVERT;
              end else if (op_q) begin
                phase_d = PH_READ;
                byte_d  = 2'd0;
                bit_d   = 3'd0;
                shift_d = 8'd0;
              end else if (cfg_i.convert_wait_time == 20'd0) begin
                phase_d = PH_IDLE;
                done    = 1'b1;
              end else begin
                phase_d = PH_CONV;
              end
            end
          end
        end
        PH_READ: begin
          tick_d  = cnt_after;
          shift_d = sampled;
          if (hit) begin
            bit_d = bit_inc;
            if (bit_inc == 3'd0) begin
              if (byte_q == 2'd0) begin
                temp_d  = {temp_q[15:8], sampled};
                byte_d  = 2'd1;
                shift_d = 8'd0;
              end else begin
                temp_d  = {sampled, temp_q[7:0]};
                phase_d = PH_IDLE;
                done    = 1'b1;
              end
            end
          end
        end
        PH_CONV: begin
          tick_d = cnt_after;
          if (hit) begin
            phase_d = PH_IDLE;
            done    = 1'b1;
          end
        end
        default: begin
          phase_d = PH_IDLE;
          tick_d  = 20'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      op_q    <= 1'b0;
      tick_q  <= 20'd0;
      bit_q   <= 3'd0;
      byte_q  <= 2'd0;
      shift_q <= 8'd0;
      temp_q  <= 16'd0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      op_q    <= op_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      byte_q  <= byte_d;
      shift_q <= shift_d;
      temp_q  <= temp_d;
    end
  end

  assign res_o.line_output_enable = oe;
  assign res_o.line_level         = lv;
  assign res_o.busy_res           = (phase_d != PH_IDLE);
  assign res_o.done_res           = done;
  assign res_o.temp_valid         = done && op_q;
  assign res_o.temperature        = temp_d;
  assign res_o.rejected           = rej;

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && done |=> phase_q == PH_IDLE && tick_q == 20'd0)
    else $error("sequence finished but phase did not return to idle");

  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && rej |=> phase_q == $past(phase_q) && tick_q == $past(tick_q)
                      && temp_q == $past(temp_q))
    else $error("ignored command changed state");

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && is_cmd && !rej |=> phase_q == PH_RHIGH && tick_q == 20'd0)
    else $error("accepted command did not start bus reset");

  a_tick_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_WRITE |-> tick_q < WSLOT_TICKS)
    else $error("write slot counter overran");

endmodule

[hw/rtl/one_wire_temperature_reader.sv]
// channel  dir  payload                                             
// req_i    in   req_type[1:0], line_in                             
// res_o    out  line_output_enable, line_level, busy_res, done_res,
//               temp_valid, temperature[15:0], rejected            
//
// one item per cycle while res_o is ready; each item gives one result through the
// input register, then result register; the bus state machine updates once per item
// rst_ni clears both valid flags and the bus state and sets config to its defaults
// a stalled result holds in the result register while the input register still takes
// one more beat; req_i.ready drops only when both are full
module one_wire_temperature_reader (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  owtr_chan_if.sink                           req_i,
  owtr_chan_if.source                         res_o,
  input  logic                                cfg_we_i,
  input  logic [owtr_pkg::CfgIdxWidth-1:0]    cfg_idx_i,
  input  logic [owtr_pkg::CfgDataWidth-1:0]   cfg_wdata_i
);
  import owtr_pkg::*;

  cfg_t cfg_q;
  logic in_valid_q;
  req_t in_q;
  logic out_valid_q;
  res_t out_q;
  res_t res;
  logic in_free;
  logic fire;

  assign in_free     = !out_valid_q || res_o.ready;
  assign fire        = in_valid_q && in_free;
  assign req_i.ready = !in_valid_q || in_free;
  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low_time       <= RESET_LOW_DEFAULT;
      cfg_q.presence_settle_time <= SETTLE_DEFAULT;
      cfg_q.convert_wait_time    <= CONV_WAIT_DEFAULT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RESET_LOW: cfg_q.reset_low_time       <= cfg_wdata_i[9:0];
        CFG_SETTLE:    cfg_q.presence_settle_time <= cfg_wdata_i[9:0];
        CFG_CONV_WAIT: cfg_q.convert_wait_time    <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        in_valid_q <= req_i.valid;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_q <= req_i.data;
    end
    if (fire) begin
      out_q <= res;
    end
  end

  owtr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (in_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import owtr_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RST_HIGH,
    PH_RST_LOW,
    PH_RST_GAP,
    PH_PRESENCE,
    PH_SETTLE,
    PH_WRITE,
    PH_READ,
    PH_CONV
  } bus_phase_e;

  // unused request code, behaves as a tick
  localparam logic [1:0] REQ_ALT_TICK = 2'd3;

  localparam int unsigned HIGH_TICKS   = 10;
  localparam int unsigned GAP_TICKS    = 50;
  localparam int unsigned SETTLE_EXTRA = 10;
  localparam int unsigned WRITE_SLOT   = 60;
  localparam int unsigned WRITE_LOW    = 8;
  localparam int unsigned WRITE_DATA   = 58;
  localparam int unsigned READ_SLOT    = 50;
  localparam int unsigned READ_LOW     = 5;
  localparam int unsigned READ_SAMPLE  = 10;
  localparam int unsigned WRITE_TICKS  = 16 * WRITE_SLOT;
  localparam int unsigned READ_TICKS   = 16 * READ_SLOT;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CfgIdxWidth-1:0]  cfg_idx_i;
  logic [CfgDataWidth-1:0] cfg_wdata_i;

  owtr_chan_if #(.T(req_t)) req_if ();
  owtr_chan_if #(.T(res_t)) res_if ();

  one_wire_temperature_reader i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  // bus master state as the block should hold it
  cfg_t        bus_cfg = '{convert_wait_time: CONV_WAIT_DEFAULT,
                           presence_settle_time: SETTLE_DEFAULT,
                           reset_low_time: RESET_LOW_DEFAULT};
  bus_phase_e  bus_ph = PH_IDLE;
  logic        op_read = 1'b0;
  logic [19:0] tick_cnt = '0;
  logic [2:0]  bit_idx = '0;
  logic [1:0]  byte_idx = '0;
  logic [7:0]  shreg = '0;
  logic [15:0] temp_word = '0;

  req_t        req_beat_q[$];
  res_t        bus_res_q[$];
  res_t        res_want;
  int unsigned mismatches = 0;
  logic        req_took = 1'b0;
  int unsigned tx_burst = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_cycles = 0;
  int unsigned rx_hold = 0;
  int unsigned rx_stall = 0;

  function automatic logic tick_done(input int unsigned limit);
    tick_cnt = tick_cnt + 20'd1;
    if (tick_cnt >= limit) begin
      tick_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void load_byte(input logic [7:0] value);
    bus_ph   = PH_WRITE;
    tick_cnt = '0;
    bit_idx  = '0;
    shreg    = value;
  endfunction

  function automatic logic end_sequence();
    bus_ph   = PH_IDLE;
    tick_cnt = '0;
    return 1'b1;
  endfunction

  // {output enable, level}
  function automatic logic [1:0] line_drive();
    case (bus_ph)
      PH_RST_HIGH, PH_CONV: return 2'b11;
      PH_RST_LOW: return 2'b10;
      PH_WRITE: begin
        if (tick_cnt < WRITE_LOW) return 2'b10;
        if (tick_cnt < WRITE_DATA) return {1'b1, shreg[0]};
        return 2'b11;
      end
      PH_READ: return (tick_cnt < READ_LOW) ? 2'b10 : 2'b01;
      default: return 2'b01;
    endcase
  endfunction

  function automatic res_t bus_step(input req_t beat);
    res_t       r;
    logic [1:0] drive;
    logic       done;
    r    = '0;
    done = 1'b0;
    if (beat.req_type == REQ_CONVERT || beat.req_type == REQ_READ) begin
      if (bus_ph != PH_IDLE) begin
        r.rejected = 1'b1;
      end else begin
        op_read  = (beat.req_type == REQ_READ);
        bus_ph   = PH_RST_HIGH;
        tick_cnt = '0;
        bit_idx  = '0;
        byte_idx = '0;
        shreg    = '0;
      end
      drive = line_drive();
    end else begin
      drive = line_drive();
      case (bus_ph)
        PH_RST_HIGH: begin
          if (tick_done(HIGH_TICKS)) begin
            if (bus_cfg.reset_low_time == '0) bus_ph = PH_RST_GAP;
            else bus_ph = PH_RST_LOW;
          end
        end
        PH_RST_LOW: if (tick_done(bus_cfg.reset_low_time)) bus_ph = PH_RST_GAP;
        PH_RST_GAP: if (tick_done(GAP_TICKS)) bus_ph = PH_PRESENCE;
        PH_PRESENCE: begin
          if (!beat.line_in) begin
            bus_ph   = PH_SETTLE;
            tick_cnt = '0;
          end
        end
        PH_SETTLE: begin
          if (tick_done(bus_cfg.presence_settle_time + SETTLE_EXTRA)) begin
            byte_idx = '0;
            load_byte(CMD_SKIP_ROM);
          end
        end
        PH_WRITE: begin
          if (tick_done(WRITE_SLOT)) begin
            shreg   = shreg >> 1;
            bit_idx = bit_idx + 3'd1;
            if (bit_idx == '0) begin
              byte_idx = byte_idx + 2'd1;
              if (byte_idx == 2'd1) begin
                load_byte(op_read ? CMD_READ_PAD : CMD_CONVERT);
              end else if (op_read) begin
                bus_ph   = PH_READ;
                byte_idx = '0;
                bit_idx  = '0;
                shreg    = '0;
              end else if (bus_cfg.convert_wait_time == '0) begin
                done = end_sequence();
              end else begin
                bus_ph = PH_CONV;
              end
            end
          end
        end
        PH_READ: begin
          if (tick_cnt == READ_SAMPLE) shreg = {beat.line_in, shreg[7:1]};
          if (tick_done(READ_SLOT)) begin
            bit_idx = bit_idx + 3'd1;
            if (bit_idx == '0) begin
              if (byte_idx == '0) begin
                temp_word[7:0] = shreg;
                byte_idx       = 2'd1;
                shreg          = '0;
              end else begin
                temp_word[15:8] = shreg;
                done            = end_sequence();
              end
            end
          end
        end
        PH_CONV: if (tick_done(bus_cfg.convert_wait_time)) done = end_sequence();
        default: ;
      endcase
    end
    r.line_output_enable = drive[1];
    r.line_level         = drive[0];
    r.busy_res           = (bus_ph != PH_IDLE);
    r.done_res           = done;
    r.temp_valid         = done && op_read;
    r.temperature        = temp_word;
    return r;
  endfunction

  task automatic push_beat(input logic [1:0] code, input logic li);
    req_beat_q.push_back('{req_type: code, line_in: li});
  endtask

  // strays are commands that land while a sequence runs
  task automatic push_tick(input logic li, input logic strays);
    if (strays && $urandom_range(0, 39) == 0)
      push_beat(($urandom_range(0, 1) == 0) ? REQ_CONVERT : REQ_READ, 1'($urandom_range(0, 1)));
    push_beat(($urandom_range(0, 7) == 0) ? REQ_ALT_TICK : REQ_TICK, li);
  endtask

  task automatic idle_ticks(input int unsigned n);
    repeat (n) push_tick(1'($urandom_range(0, 1)), 1'b0);
  endtask

  task automatic busy_ticks(input int unsigned n);
    repeat (n) push_tick(1'($urandom_range(0, 1)), 1'b1);
  endtask

  task automatic run_sequence(input logic do_read);
    int unsigned absent;
    absent = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 300) : $urandom_range(0, 4);
    idle_ticks(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
    push_beat(do_read ? REQ_READ : REQ_CONVERT, 1'($urandom_range(0, 1)));
    busy_ticks(HIGH_TICKS + bus_cfg.reset_low_time + GAP_TICKS);
    // line stays high until the presence pulse
    repeat (absent) push_tick(1'b1, 1'b1);
    push_tick(1'b0, 1'b1);
    busy_ticks(bus_cfg.presence_settle_time + SETTLE_EXTRA + WRITE_TICKS +
               (do_read ? READ_TICKS : bus_cfg.convert_wait_time));
  endtask

  task automatic drain();
    while (req_beat_q.size() != 0 || bus_res_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [19:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
  endtask

  task automatic apply_cfg(input logic [9:0] rl, input logic [9:0] st, input logic [19:0] cw);
    drain();
    write_reg(CFG_RESET_LOW, {10'd0, rl});
    write_reg(CFG_SETTLE, {10'd0, st});
    write_reg(CFG_CONV_WAIT, cw);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    bus_cfg.reset_low_time       = rl;
    bus_cfg.presence_settle_time = st;
    bus_cfg.convert_wait_time    = cw;
  endtask

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 100)
        $display("%0t %s: expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  // request beats
  always @(posedge clk_i) begin
    req_took = req_if.valid && req_if.ready;
    if (req_took) begin
      bus_res_q.push_back(bus_step(req_if.data));
      void'(req_beat_q.pop_front());
    end
  end

  always @(negedge clk_i) begin
    if (!(req_if.valid && !req_took)) begin
      if (tx_gap > 0) begin
        tx_gap--;
        req_if.valid <= 1'b0;
      end else if (req_beat_q.size() > 0) begin
        req_if.valid <= 1'b1;
        req_if.data  <= req_beat_q[0];
        if (tx_burst == 0) begin
          tx_burst = $urandom_range(1, 150);
          tx_gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          tx_burst--;
        end
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // result side: calm stretches, short stalls, and one long hold-off
  always @(negedge clk_i) begin
    rx_cycles++;
    if (rx_cycles == 400) rx_hold = 300;
    if (rx_hold > 0) begin
      rx_hold--;
      res_if.ready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      res_if.ready <= 1'b0;
    end else if (rx_cycles[8] && $urandom_range(0, 3) == 0) begin
      rx_stall = $urandom_range(0, 5);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (res_if.valid && res_if.ready) begin
      if (bus_res_q.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result beat, actual %0h", $time, res_if.data);
      end else begin
        res_want = bus_res_q.pop_front();
        check_field("line_output_enable", 16'(res_want.line_output_enable),
                    16'(res_if.data.line_output_enable));
        check_field("line_level", 16'(res_want.line_level), 16'(res_if.data.line_level));
        check_field("busy_res", 16'(res_want.busy_res), 16'(res_if.data.busy_res));
        check_field("done_res", 16'(res_want.done_res), 16'(res_if.data.done_res));
        check_field("temp_valid", 16'(res_want.temp_valid), 16'(res_if.data.temp_valid));
        check_field("temperature", res_want.temperature, res_if.data.temperature);
        check_field("rejected", 16'(res_want.rejected), 16'(res_if.data.rejected));
      end
    end
  end

  initial begin
    #200_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    res_if.ready = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_RESET_LOW;
    cfg_wdata_i  = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // idle ticks of both codes and levels
    push_beat(REQ_TICK, 1'b0);
    push_beat(REQ_TICK, 1'b1);
    push_beat(REQ_ALT_TICK, 1'b0);
    push_beat(REQ_ALT_TICK, 1'b1);

    // zero reset and settle times, short conversion
    apply_cfg(10'd0, 10'd0, 20'd25);
    run_sequence(1'b0);

    // no presence pulse: the bus waits with no timeout
    apply_cfg(10'd30, 10'd5, 20'd0);
    push_beat(REQ_READ, 1'b1);
    busy_ticks(HIGH_TICKS + bus_cfg.reset_low_time + GAP_TICKS);
    repeat (250) push_tick(1'b1, 1'b1);

    drain();
    repeat (20) @(negedge clk_i);
    if (mismatches == 0 && bus_res_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
